FILE: rtl/tst_pkg.sv
package tst_pkg;

    // Default number of timer slots.
    localparam int unsigned SLOTS_DEFAULT = 16;

    // Widths of the count fields in a result.
    localparam int unsigned OUT_CNT_W = 7;

    typedef enum logic [1:0] {
        OP_TICK         = 2'd0,
        OP_SET_ONCE     = 2'd1,
        OP_SET_PERIODIC = 2'd2,
        OP_CLEAR        = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        RES_FIRED   = 2'd0,
        RES_SUMMARY = 2'd1,
        RES_SET     = 2'd2,
        RES_CLEAR   = 2'd3
    } res_kind_t;

    typedef enum logic [1:0] {
        SK_EMPTY    = 2'd0,
        SK_ONESHOT  = 2'd1,
        SK_PERIODIC = 2'd2
    } slot_kind_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] now_ms;
        logic [31:0] duration_ms;
        logic [15:0] clear_id;
    } in_t;

    typedef struct packed {
        res_kind_t              kind;
        logic [15:0]            task_id;
        logic [OUT_CNT_W-1:0]   fired_count;
        logic                   ok;
        logic [OUT_CNT_W-1:0]   active_count;
        logic                   last;
    } out_t;

    // One row of the slot memory.
    typedef struct packed {
        logic [15:0] ident;
        logic [31:0] period;
        logic [31:0] due;
    } row_t;

    localparam int unsigned ROW_W = $bits(row_t);

endpackage

FILE: rtl/tst_slot_ram.sv
module tst_slot_ram #(
    parameter int unsigned DEPTH  = tst_pkg::SLOTS_DEFAULT,
    parameter int unsigned WIDTH  = tst_pkg::ROW_W,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read data holds between reads so a stalled consumer sees a stable row.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/timer_slot_table_core.sv
// A set scans from slot 0 for the first empty slot and fills it, or replies with id 0 when
// the table is full. A clear scans the live slots for the id and replies, with ok set on a
// match. A tick makes two passes: the first reads every live slot and marks the due ones,
// the second emits a fired result per due slot and rearms or empties it; a summary ends it.
// One item at a time.
// Reset (rst_n low, asynchronous) empties every slot and sets the next id to 1 at once.
module timer_slot_table_core #(
    parameter int unsigned SLOTS = tst_pkg::SLOTS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  tst_pkg::in_t in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output tst_pkg::out_t out_data
);

    import tst_pkg::*;

    // The scan index must reach SLOTS itself, the memory address only SLOTS - 1.
    localparam int unsigned IDX_W  = $clog2(SLOTS + 1);
    localparam int unsigned ADDR_W = $clog2(SLOTS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_T1_RD,
        ST_T1_EV,
        ST_T2_CHK,
        ST_T2_EV,
        ST_T_SUM,
        ST_SET,
        ST_CLR_CHK,
        ST_CLR_EV
    } state_t;

    state_t            state_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  active_reg;
    logic [IDX_W-1:0]  fired_reg;
    logic [15:0]       next_id_reg;
    slot_kind_t        kind_reg [SLOTS];
    logic [SLOTS-1:0]  due_vec_reg;
    op_t               op_reg;
    logic [31:0]       now_reg;
    logic [31:0]       dur_reg;
    logic [15:0]       cid_reg;
    logic              out_valid_reg;
    out_t              out_data_reg;

    logic [ADDR_W-1:0] slot_sel;
    logic              idx_end;
    logic              out_free;
    slot_kind_t        kind_sel;
    logic              rd_en;
    logic              wr_en;
    row_t              wr_row;
    row_t              rd_row;
    logic [ROW_W-1:0]  rd_bits;
    logic [31:0]       elapsed;
    logic              slot_due;
    logic [15:0]       next_id_inc;
    logic [IDX_W-1:0]  idx_inc;

    assign slot_sel = idx_reg[ADDR_W-1:0];
    assign idx_end  = (idx_reg == IDX_W'(SLOTS));
    assign kind_sel = kind_reg[slot_sel];
    assign idx_inc  = idx_reg + IDX_W'(1);

    // The output register can take a new result when it is empty or being drained.
    assign out_free = !out_valid_reg || out_ready;

    assign rd_row = row_t'(rd_bits);

    // A slot is due when the signed difference now - due is not negative.
    assign elapsed  = now_reg - rd_row.due;
    assign slot_due = !elapsed[31];

    // Ids run from 1 to 65535 and then wrap back to 1.
    assign next_id_inc = (next_id_reg == 16'hFFFF) ? 16'd1 : next_id_reg + 16'd1;

    // Memory port control. Reads are issued from the read and check states and consumed in
    // the evaluate state after them; writes happen only when a slot is filled or a periodic
    // slot rearms, always on the slot under evaluation, so a read never overlaps a write to it.
    always_comb
    begin
        rd_en  = 1'b0;
        wr_en  = 1'b0;
        wr_row = rd_row;
        unique case (state_reg)
            ST_T1_RD:
            begin
                rd_en = !idx_end && (kind_sel != SK_EMPTY);
            end
            ST_T2_CHK:
            begin
                rd_en = !idx_end && due_vec_reg[slot_sel];
            end
            ST_CLR_CHK:
            begin
                rd_en = !idx_end && (kind_sel != SK_EMPTY);
            end
            ST_T2_EV:
            begin
                wr_en      = out_free && (kind_sel == SK_PERIODIC);
                wr_row.due = now_reg + rd_row.period;
            end
            ST_SET:
            begin
                wr_en         = out_free && (kind_sel == SK_EMPTY);
                wr_row.ident  = next_id_reg;
                wr_row.period = dur_reg;
                wr_row.due    = now_reg + dur_reg;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    tst_slot_ram #(
        .DEPTH  (SLOTS),
        .WIDTH  (ROW_W),
        .ADDR_W (ADDR_W)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot_sel),
        .wr_data (ROW_W'(wr_row)),
        .rd_en   (rd_en),
        .rd_addr (slot_sel),
        .rd_data (rd_bits)
    );

    // Sequencer. A tick first counts the due slots so that the final active count is
    // known before the first fired result leaves; the second pass emits and updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            active_reg    <= '0;
            fired_reg     <= '0;
            next_id_reg   <= 16'd1;
            due_vec_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                kind_reg[i] <= SK_EMPTY;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg      <= in_data.op;
                        now_reg     <= in_data.now_ms;
                        dur_reg     <= in_data.duration_ms;
                        cid_reg     <= in_data.clear_id;
                        fired_reg   <= '0;
                        due_vec_reg <= '0;
                        idx_reg     <= '0;
                        unique case (in_data.op)
                            OP_TICK:
                            begin
                                state_reg <= ST_T1_RD;
                            end
                            OP_SET_ONCE, OP_SET_PERIODIC:
                            begin
                                state_reg <= ST_SET;
                            end
                            OP_CLEAR:
                            begin
                                // Id 0 never matches, so skip straight to the reply.
                                if (in_data.clear_id == 16'd0)
                                begin
                                    idx_reg <= IDX_W'(SLOTS);
                                end
                                state_reg <= ST_CLR_CHK;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end

                ST_T1_RD:
                begin
                    priority if (idx_end)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_T2_CHK;
                    end
                    else if (kind_sel == SK_EMPTY)
                    begin
                        idx_reg <= idx_inc;
                    end
                    else
                    begin
                        state_reg <= ST_T1_EV;
                    end
                end

                ST_T1_EV:
                begin
                    if (slot_due)
                    begin
                        due_vec_reg[slot_sel] <= 1'b1;
                        fired_reg             <= fired_reg + IDX_W'(1);
                        if (kind_sel == SK_ONESHOT)
                        begin
                            active_reg <= active_reg - IDX_W'(1);
                        end
                    end
                    idx_reg   <= idx_inc;
                    state_reg <= ST_T1_RD;
                end

                ST_T2_CHK:
                begin
                    priority if (idx_end)
                    begin
                        state_reg <= ST_T_SUM;
                    end
                    else if (!due_vec_reg[slot_sel])
                    begin
                        idx_reg <= idx_inc;
                    end
                    else
                    begin
                        state_reg <= ST_T2_EV;
                    end
                end

                ST_T2_EV:
                begin
                    if (out_free)
                    begin
                        out_valid_reg              <= 1'b1;
                        out_data_reg.kind          <= RES_FIRED;
                        out_data_reg.task_id       <= rd_row.ident;
                        out_data_reg.fired_count   <= '0;
                        out_data_reg.ok            <= 1'b0;
                        out_data_reg.active_count  <= OUT_CNT_W'(active_reg);
                        out_data_reg.last          <= 1'b0;
                        if (kind_sel == SK_ONESHOT)
                        begin
                            kind_reg[slot_sel] <= SK_EMPTY;
                        end
                        idx_reg   <= idx_inc;
                        state_reg <= ST_T2_CHK;
                    end
                end

                ST_T_SUM:
                begin
                    if (out_free)
                    begin
                        out_valid_reg              <= 1'b1;
                        out_data_reg.kind          <= RES_SUMMARY;
                        out_data_reg.task_id       <= 16'd0;
                        out_data_reg.fired_count   <= OUT_CNT_W'(fired_reg);
                        out_data_reg.ok            <= 1'b0;
                        out_data_reg.active_count  <= OUT_CNT_W'(active_reg);
                        out_data_reg.last          <= 1'b1;
                        state_reg                  <= ST_IDLE;
                    end
                end

                ST_SET:
                begin
                    if (out_free)
                    begin
                        priority if (kind_sel == SK_EMPTY)
                        begin
                            kind_reg[slot_sel] <= (op_reg == OP_SET_ONCE) ? SK_ONESHOT
                                                                          : SK_PERIODIC;
                            next_id_reg                <= next_id_inc;
                            active_reg                 <= active_reg + IDX_W'(1);
                            out_valid_reg              <= 1'b1;
                            out_data_reg.kind          <= RES_SET;
                            out_data_reg.task_id       <= next_id_reg;
                            out_data_reg.fired_count   <= '0;
                            out_data_reg.ok            <= 1'b0;
                            out_data_reg.active_count  <= OUT_CNT_W'(active_reg + IDX_W'(1));
                            out_data_reg.last          <= 1'b1;
                            state_reg                  <= ST_IDLE;
                        end
                        else if (idx_reg == IDX_W'(SLOTS - 1))
                        begin
                            // Table full: reply with id 0 and change nothing.
                            out_valid_reg              <= 1'b1;
                            out_data_reg.kind          <= RES_SET;
                            out_data_reg.task_id       <= 16'd0;
                            out_data_reg.fired_count   <= '0;
                            out_data_reg.ok            <= 1'b0;
                            out_data_reg.active_count  <= OUT_CNT_W'(active_reg);
                            out_data_reg.last          <= 1'b1;
                            state_reg                  <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_inc;
                        end
                    end
                end

                ST_CLR_CHK:
                begin
                    priority if (idx_end)
                    begin
                        if (out_free)
                        begin
                            out_valid_reg              <= 1'b1;
                            out_data_reg.kind          <= RES_CLEAR;
                            out_data_reg.task_id       <= cid_reg;
                            out_data_reg.fired_count   <= '0;
                            out_data_reg.ok            <= 1'b0;
                            out_data_reg.active_count  <= OUT_CNT_W'(active_reg);
                            out_data_reg.last          <= 1'b1;
                            state_reg                  <= ST_IDLE;
                        end
                    end
                    else if (kind_sel == SK_EMPTY)
                    begin
                        idx_reg <= idx_inc;
                    end
                    else
                    begin
                        state_reg <= ST_CLR_EV;
                    end
                end

                ST_CLR_EV:
                begin
                    if (rd_row.ident == cid_reg)
                    begin
                        if (out_free)
                        begin
                            kind_reg[slot_sel]         <= SK_EMPTY;
                            active_reg                 <= active_reg - IDX_W'(1);
                            out_valid_reg              <= 1'b1;
                            out_data_reg.kind          <= RES_CLEAR;
                            out_data_reg.task_id       <= cid_reg;
                            out_data_reg.fired_count   <= '0;
                            out_data_reg.ok            <= 1'b1;
                            out_data_reg.active_count  <= OUT_CNT_W'(active_reg - IDX_W'(1));
                            out_data_reg.last          <= 1'b1;
                            state_reg                  <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_inc;
                        state_reg <= ST_CLR_CHK;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A new item is taken only between operations; a pending result may still wait.
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
